FILE: rtl/pld_pkg.sv
// types and constants for the pixel luma extractor with 3x3 bayer demosaic
// no dependencies; imported by pixel_luma_extract_debayer_core
package pld_pkg;

	// camera formats held in the pixel_format register
	typedef enum logic [2:0] {
		FMT_YUV422 = 3'd0,
		FMT_YUV444 = 3'd1,
		FMT_RGB8   = 3'd2,
		FMT_MONO16 = 3'd3,
		FMT_MONO8  = 3'd4
	} fmt_t;

	// bayer site codes after the bggr swap
	typedef enum logic [2:0] {
		SITE_PLAIN   = 3'd0,
		SITE_GREEN_R = 3'd4,
		SITE_RED     = 3'd5,
		SITE_GREEN_B = 3'd6,
		SITE_BLUE    = 3'd7
	} site_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BGGR_SWAP    = 1'd1;

	// reset values
	localparam logic [2:0] PIXEL_FORMAT_RST = 3'd4;

	// swap mask for bggr raw order
	localparam logic [2:0] BGGR_MASK = 3'b010;

	// weighted sums are at most 220 * 255, which fits 16 bits
	localparam int unsigned SUM_W  = 16;
	localparam int unsigned LUMA_W = 16;

	// bt.601 offset
	localparam logic [7:0] RGB_OFFSET = 8'd16;

endpackage

FILE: rtl/pixel_luma_extract_debayer_core.sv
// pixel luma extractor: yuv/rgb/mono16 luma and mono8 3x3 bayer kernels
// depends on pld_pkg for format, site and register codes
//
// One request carries a pixel with its eight 3x3 neighbours and a bayer site
// type; the block answers with one luma value, or with nothing when the
// configured format is unsupported (codes 5 to 7). yuv422/yuv444 pass the
// low byte of center, rgb8 gives 16 + (66R + 129G + 25B) / 256, mono16 passes
// the 16-bit center and mono8 applies a fixed-weight 3x3 kernel chosen by the
// site type (xored with 2 when bggr_swap is set), then divides by 256; other
// site types pass the centre byte. A request passes through the input
// register, the weighted sums and then the result register before its result
// is offered. A new request is taken every cycle while out_ready is high; the
// input register and the result register each hold one item, so a stalled
// result stops new requests only once the input register is full too.
// Configuration is written through cfg_we/cfg_index/cfg_data and must only
// change while no request is in flight.
module pixel_luma_extract_debayer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [pld_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pld_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [15:0]                         center,
	input  logic [7:0]                          green_in,
	input  logic [7:0]                          blue_in,
	input  logic [7:0]                          west,
	input  logic [7:0]                          east,
	input  logic [7:0]                          north,
	input  logic [7:0]                          south,
	input  logic [7:0]                          north_west,
	input  logic [7:0]                          north_east,
	input  logic [7:0]                          south_west,
	input  logic [7:0]                          south_east,
	input  logic [2:0]                          site_type,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pld_pkg::LUMA_W-1:0]          luma
);
	import pld_pkg::*;

	// configuration registers
	logic [2:0] pixel_format_q;
	logic       bggr_swap_q;

	// input register
	logic        valid_s1;
	logic [15:0] center_s1;
	logic [7:0]  green_s1, blue_s1;
	logic [7:0]  w_s1, e_s1, n_s1, s_s1, nw_s1, ne_s1, sw_s1, se_s1;
	logic [2:0]  site_s1;

	// result register
	logic              valid_s2;
	logic [LUMA_W-1:0] luma_s2;

	// handshake
	logic adv_s2;    // result register free or being emptied
	logic adv_s1;    // input register moves on this cycle
	logic take_in;   // request accepted

	// datapath
	logic [SUM_W-1:0]  c16, w16, e16, n16, s16, nw16, ne16, sw16, se16;
	logic [SUM_W-1:0]  g16, b16;
	logic [SUM_W-1:0]  rgb_sum, kern_sum;
	logic [2:0]        site_sw;
	logic [7:0]        kern_luma;
	logic [LUMA_W-1:0] luma_d;
	logic              has_result;

	// a stalled result only blocks the input register once it too is full
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;
	assign take_in  = in_valid && in_ready;

	// configuration writes, one register per index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= PIXEL_FORMAT_RST;
			bggr_swap_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_data;
				REG_BGGR_SWAP:    bggr_swap_q    <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// input register: valid is control, payload loads on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			center_s1 <= center;
			green_s1  <= green_in;
			blue_s1   <= blue_in;
			w_s1      <= west;
			e_s1      <= east;
			n_s1      <= north;
			s_s1      <= south;
			nw_s1     <= north_west;
			ne_s1     <= north_east;
			sw_s1     <= south_west;
			se_s1     <= south_east;
			site_s1   <= site_type;
		end
	end

	// zero-extend the bytes to the sum width
	assign c16  = SUM_W'(center_s1[7:0]);
	assign g16  = SUM_W'(green_s1);
	assign b16  = SUM_W'(blue_s1);
	assign w16  = SUM_W'(w_s1);
	assign e16  = SUM_W'(e_s1);
	assign n16  = SUM_W'(n_s1);
	assign s16  = SUM_W'(s_s1);
	assign nw16 = SUM_W'(nw_s1);
	assign ne16 = SUM_W'(ne_s1);
	assign sw16 = SUM_W'(sw_s1);
	assign se16 = SUM_W'(se_s1);

	// bt.601 weighted sum; at most 220 * 255 so no overflow
	assign rgb_sum = c16 * 16'd66 + g16 * 16'd129 + b16 * 16'd25;

	// bggr raw order swaps red and blue rows
	assign site_sw = bggr_swap_q ? (site_s1 ^ BGGR_MASK) : site_s1;

	// per-site kernels, all weights summing to 220
	always_comb begin
		kern_sum = '0;
		case (site_sw)
			SITE_GREEN_B: kern_sum = c16 * 16'd129 + n16 * 16'd33 + s16 * 16'd33
				+ e16 * 16'd12 + w16 * 16'd13;
			SITE_GREEN_R: kern_sum = c16 * 16'd129 + n16 * 16'd12 + s16 * 16'd13
				+ e16 * 16'd33 + w16 * 16'd33;
			SITE_RED: kern_sum = c16 * 16'd66 + w16 * 16'd32 + e16 * 16'd32
				+ n16 * 16'd32 + s16 * 16'd33 + se16 * 16'd6 + sw16 * 16'd6
				+ ne16 * 16'd6 + nw16 * 16'd7;
			SITE_BLUE: kern_sum = c16 * 16'd25 + w16 * 16'd32 + e16 * 16'd32
				+ n16 * 16'd32 + s16 * 16'd33 + se16 * 16'd16 + sw16 * 16'd16
				+ ne16 * 16'd17 + nw16 * 16'd17;
			default: kern_sum = c16 << 8;
		endcase
	end

	// divide by 256; plain sites come back as the centre byte
	assign kern_luma = kern_sum[15:8];

	// format selection
	always_comb begin
		luma_d     = '0;
		has_result = 1'b1;
		case (fmt_t'(pixel_format_q))
			FMT_YUV422, FMT_YUV444: luma_d = LUMA_W'(center_s1[7:0]);
			FMT_RGB8:   luma_d = LUMA_W'(rgb_sum[15:8]) + LUMA_W'(RGB_OFFSET);
			FMT_MONO16: luma_d = center_s1;
			FMT_MONO8:  luma_d = LUMA_W'(kern_luma);
			default:    has_result = 1'b0;
		endcase
	end

	// result register; unsupported formats are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= adv_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			luma_s2 <= luma_d;
		end
	end

	assign out_valid = valid_s2;
	assign luma      = luma_s2;

	// top byte is only used by mono16
	a_narrow_luma: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pixel_format_q != FMT_MONO16) |-> luma[15:8] == 8'd0)
		else $error("luma top byte set outside mono16");

	// rgb luma lies in the bt.601 range
	a_rgb_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pixel_format_q == FMT_RGB8) |-> (luma >= 16'd16) && (luma <= 16'd235))
		else $error("rgb luma out of range");

	// an unsupported format never yields a result
	a_drop_unsupported: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !has_result |=> !out_valid)
		else $error("result produced for unsupported format");

	// input register cannot be overwritten while holding an item
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |-> !in_ready)
		else $error("input register overwritten");

endmodule
